// ===== src/ed_pkg.sv =====
package ed_pkg;

  // Element and result field widths
  localparam int ELEM_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int MAX_DIM   = 64;
  localparam int SUM_W     = 38;
  localparam int DIST_W    = 27;
  localparam int ACC_W     = 39;

  // Derived datapath widths
  localparam int DIFF_W = ELEM_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 2 * ELEM_BITS;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int RAD_W  = 2 * DIST_W;
  localparam int REM_W  = DIST_W + 3;
  localparam int ITER_W = $clog2(DIST_W);

  // Stream payload widths
  localparam int IN_DATA_W  = ((2 * ELEM_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SUM_W + DIST_W + 7) / 8) * 8;

  // Saturation bound of the sum of squares
  localparam longint unsigned ELEM_SPAN = (64'd1 << ELEM_BITS) - 64'd1;
  localparam logic [SUM_W-1:0] SAT_SUM =
    SUM_W'(longint'(MAX_DIM) * ELEM_SPAN * ELEM_SPAN);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } ed_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic root_start;
    logic root_run;
  } ed_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic root_last;
  } ed_status_t;

endpackage

// ===== src/ed_ctrl.sv =====
module ed_ctrl
  import ed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output ed_cmd_t    cmd,
  input  ed_status_t status
);

  ed_state_t state;
  ed_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    cmd.take       = 1'b0;
    cmd.root_start = 1'b0;
    cmd.root_run   = 1'b0;
    case (state)
      ST_ACC: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.root_start = 1'b1;
          state_next     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_run = 1'b1;
        if (status.root_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

endmodule

// ===== src/ed_datapath.sv =====
module ed_datapath
  import ed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [ELEM_BITS-1:0]  from_elem,
  input  logic [ELEM_BITS-1:0]  to_elem,
  input  ed_cmd_t               cmd,
  output ed_status_t            status,
  output logic [SUM_W-1:0]      sum_of_squares,
  output logic [DIST_W-1:0]     distance_q8,
  output logic                  too_long
);

  // Accumulation pipeline
  logic                     valid_a;
  logic signed [DIFF_W-1:0] diff_a;
  logic                     valid_b;
  logic [SQ_W-1:0]          sq_b;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_next;
  logic [CNT_W-1:0]         count;
  logic                     ovf;
  logic                     full;
  logic [SUM_W-1:0]         sum_sel;

  // Square root unit
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [DIST_W-1:0] root;
  logic [ITER_W-1:0] iter;

  assign full = (count == CNT_W'(MAX_DIM));
  assign prod = diff_a * diff_a;

  // Add and clamp at the saturation bound
  always_comb begin
    acc_next = acc + ACC_W'(sq_b);
    if (acc_next > ACC_W'(SAT_SUM)) begin
      acc_next = ACC_W'(SAT_SUM);
    end
  end

  // Pick the sum reported for this vector
  always_comb begin
    if (ovf || (acc > ACC_W'(SAT_SUM))) begin
      sum_sel = SAT_SUM;
    end else begin
      sum_sel = acc[SUM_W-1:0];
    end
  end

  // Difference stage: drop pairs beyond the vector limit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      count   <= '0;
      ovf     <= 1'b0;
    end else if (cmd.root_start) begin
      valid_a <= 1'b0;
      count   <= '0;
      ovf     <= 1'b0;
    end else begin
      valid_a <= cmd.take && !full;
      if (cmd.take) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    diff_a <= DIFF_W'($signed(from_elem)) - DIFF_W'($signed(to_elem));
    sq_b   <= prod[SQ_W-1:0];
  end

  // Square and accumulate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
      acc     <= '0;
    end else begin
      valid_b <= valid_a;
      if (cmd.root_start) begin
        acc <= '0;
      end else if (valid_b) begin
        acc <= acc_next;
      end
    end
  end

  assign status.pipe_busy = valid_a || valid_b;

  // One root bit per step, two radicand bits brought down each time
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.root_start) begin
      iter <= '0;
    end else if (cmd.root_run) begin
      iter <= iter + ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      rad            <= RAD_W'({sum_sel, {(2 * FRAC_BITS){1'b0}}});
      rem            <= '0;
      root           <= '0;
      sum_of_squares <= sum_sel;
      too_long       <= ovf;
    end else if (cmd.root_run) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[DIST_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[DIST_W-2:0], 1'b0};
      end
    end
  end

  assign status.root_last = (iter == ITER_W'(DIST_W - 1));
  assign distance_q8      = root;

endmodule

// ===== src/euclidean_distance_unit.sv =====
// Euclidean distance unit.
// Input channel (s_*): one element pair per item, from_elem in s_tdata[15:0],
// to_elem in s_tdata[31:16]; s_tlast marks the final pair of the vectors.
// Output channel (m_*): one result per vector, sum of squares in
// m_tdata[37:0], distance (floor square root, 8 fraction bits) in
// m_tdata[64:38]; m_tuser is high when more than 64 pairs arrived, in which
// case the sum reads as its saturation value.
// Within a vector, pairs are taken one per cycle through a three-stage
// subtract / square / accumulate pipeline. After the last pair, the pipeline
// drains and then the square root unit, which produces one result bit per
// cycle, runs until every bit of the distance is formed; the result is then
// presented on the output channel.
// s_tready is low from the last pair until the result is taken.
// The result holds in the output register while m_tready is low.
// Reset clears the running sum, the pair count and the overflow flag, and
// leaves the unit ready for a new vector; the state clears again when the
// square root of each vector starts.
module euclidean_distance_unit
  import ed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // from_elem, to_elem
  input  logic                  s_tlast,   // last_elem
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // sum_of_squares, distance_q8, zero fill
  output logic                  m_tuser    // too_long
);

  ed_cmd_t             cmd;
  ed_status_t          status;
  logic [SUM_W-1:0]    sum_of_squares;
  logic [DIST_W-1:0]   distance_q8;

  ed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  ed_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .from_elem      (s_tdata[ELEM_BITS-1:0]),
    .to_elem        (s_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .cmd            (cmd),
    .status         (status),
    .sum_of_squares (sum_of_squares),
    .distance_q8    (distance_q8),
    .too_long       (m_tuser)
  );

  // Pack the result fields, lowest first
  assign m_tdata = OUT_DATA_W'({distance_q8, sum_of_squares});

endmodule

// ===== src/ed_checker.sv =====
module ed_checker
  import ed_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // No new pair while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");

  // Overflow reports the saturated sum
  a_sat_sum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[SUM_W-1:0] == SAT_SUM)
    else $error("overflow without saturated sum");

  // Zero sum gives zero distance
  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[SUM_W-1:0] == '0) |-> m_tdata[SUM_W+DIST_W-1:SUM_W] == '0)
    else $error("nonzero distance for zero sum");

  // Zero fill above the distance field
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:SUM_W+DIST_W] == '0)
    else $error("fill bits set");

endmodule

bind euclidean_distance_unit ed_checker u_ed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== sim/tb_euclidean_distance_unit.sv =====
`timescale 1ns / 100ps

module tb_euclidean_distance_unit;
  import ed_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PAIRS   = 1190;
  localparam int IDLE_PCT       = 13;

  typedef enum int {
    DATA_FULL,
    DATA_SMALL,
    DATA_EXTREME,
    DATA_EQUAL
  } data_mode_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } dist_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;    // from_elem, to_elem
  logic                  s_tlast;    // last_elem
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // sum_of_squares, distance_q8, zero fill
  logic                  m_tuser;    // too_long

  // Predictor state for the vector in progress
  longint unsigned sq_sum = 0;
  int              pair_count = 0;
  bit              overrun = 1'b0;
  dist_result_t    pending_results[$];

  int errors = 0;
  int pairs_sent;
  int stall_cycles;
  bit idle_on;

  euclidean_distance_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Digit-by-digit integer square root
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Add one pair to the running sum; queue the result on the last pair
  function automatic void accumulate_pair(logic [ELEM_BITS-1:0] fe,
                                          logic [ELEM_BITS-1:0] te, bit le);
    longint          d;
    longint unsigned mag;
    longint unsigned s;
    longint unsigned sat;
    longint unsigned root;
    dist_result_t    r;
    sat = longint'(SAT_SUM);
    if (pair_count < MAX_DIM) begin
      d = longint'($signed(fe)) - longint'($signed(te));
      mag = (d < 0) ? longint'(-d) : longint'(d);
      s = sq_sum + mag * mag;
      if (s > sat) s = sat;
      sq_sum = s;
      pair_count++;
    end else begin
      overrun = 1'b1;
      sq_sum = sat;
    end
    if (le) begin
      s = overrun ? sat : sq_sum;
      if (s > sat) s = sat;
      root = floor_root(s << (2 * FRAC_BITS));
      r.sum = s[SUM_W-1:0];
      r.distance = root[DIST_W-1:0];
      r.too_long = overrun;
      pending_results.insert(pending_results.size(), r);
      sq_sum = 0;
      pair_count = 0;
      overrun = 1'b0;
    end
  endfunction

  // Predict on accepted pairs, check accepted results against the oldest one
  always @(posedge clk) begin : result_monitor
    dist_result_t want;
    logic [SUM_W-1:0]  got_sum;
    logic [DIST_W-1:0] got_dist;
    if (!rst) begin
      if (s_tvalid && s_tready)
        accumulate_pair(s_tdata[ELEM_BITS-1:0], s_tdata[2*ELEM_BITS-1:ELEM_BITS], s_tlast);
      if (m_tvalid && m_tready) begin
        got_sum = m_tdata[SUM_W-1:0];
        got_dist = m_tdata[SUM_W+DIST_W-1:SUM_W];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result sum=%0d dist=%0d too_long=%0b",
                   $time, got_sum, got_dist, m_tuser);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got_sum !== want.sum) begin
            $display("%0t: sum_of_squares expected %0d actual %0d",
                     $time, want.sum, got_sum);
            errors++;
          end
          if (got_dist !== want.distance) begin
            $display("%0t: distance_q8 expected %0d actual %0d",
                     $time, want.distance, got_dist);
            errors++;
          end
          if (m_tuser !== want.too_long) begin
            $display("%0t: too_long expected %0b actual %0b",
                     $time, want.too_long, m_tuser);
            errors++;
          end
        end
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready <= (idle_on && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, pending_results.size());
      $display("** euclidean_distance_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one pair and hold it until accepted
  task automatic send_pair(input logic [ELEM_BITS-1:0] fe, input logic [ELEM_BITS-1:0] te,
                           input bit le);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {te, fe};
    s_tlast <= le;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pairs_sent++;
  endtask

  function automatic logic [ELEM_BITS-1:0] pick_elem(data_mode_t mode);
    logic [ELEM_BITS-1:0] v;
    case (mode)
      DATA_SMALL: begin
        v = ELEM_BITS'($urandom_range(16) - 8);
      end
      DATA_EXTREME: begin
        case ($urandom_range(3))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: begin
        v = ELEM_BITS'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic send_vector(input int len, input data_mode_t mode);
    logic [ELEM_BITS-1:0] fe;
    logic [ELEM_BITS-1:0] te;
    for (int i = 0; i < len; i++) begin
      fe = pick_elem(mode);
      te = (mode == DATA_EQUAL) ? fe : pick_elem(mode);
      send_pair(fe, te, i == len - 1);
    end
  endtask

  // Single-pair vectors at the field extremes, then short multi-pair vectors
  task automatic test_extremes;
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h7FFF, 16'h7FFF, 1'b1);
    send_pair(16'h0001, 16'h0000, 1'b1);
    send_pair(16'hFFFF, 16'h0000, 1'b1);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    // hold back the result until the last pair
    send_pair(16'h0003, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0004, 1'b0);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h1234, 16'hEDCB, 1'b0);
    send_pair(16'hFFFF, 16'hFFFE, 1'b1);
  endtask

  // Exactly the maximum length at maximum difference reaches the bound
  task automatic test_full_length;
    for (int i = 0; i < MAX_DIM; i++)
      send_pair(16'h7FFF, 16'h8000, i == MAX_DIM - 1);
    send_vector(MAX_DIM, DATA_FULL);
  endtask

  // Pairs beyond the maximum length saturate and flag the result
  task automatic test_too_long;
    send_vector(MAX_DIM + 1, DATA_FULL);
    send_vector(MAX_DIM + 2, DATA_EQUAL);
    send_vector(MAX_DIM + 16, DATA_SMALL);
    // state must be clean again after an overlong vector
    send_pair(16'h0002, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0001, 1'b1);
  endtask

  task automatic test_random_vectors;
    int first;
    int len;
    int roll;
    data_mode_t mode;
    first = pairs_sent;
    while (pairs_sent - first < RANDOM_PAIRS) begin
      // run a stretch with both sides at full rate
      idle_on = !((pairs_sent - first) >= 500 && (pairs_sent - first) < 800);
      roll = $urandom_range(99);
      if (roll < 70)      len = $urandom_range(12, 1);
      else if (roll < 90) len = $urandom_range(MAX_DIM, 13);
      else if (roll < 97) len = $urandom_range(MAX_DIM, MAX_DIM - 1);
      else                len = $urandom_range(MAX_DIM + 8, MAX_DIM + 1);
      roll = $urandom_range(99);
      if (roll < 55)      mode = DATA_FULL;
      else if (roll < 75) mode = DATA_SMALL;
      else if (roll < 92) mode = DATA_EXTREME;
      else                mode = DATA_EQUAL;
      send_vector(len, mode);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    pairs_sent = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_full_length();
    test_too_long();
    test_random_vectors();

    // drop valid and let the last results drain
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** euclidean_distance_unit: PASSED **");
    end else begin
      $display("** euclidean_distance_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== euclidean_distance_unit.f =====
src/ed_pkg.sv
src/ed_ctrl.sv
src/ed_datapath.sv
src/euclidean_distance_unit.sv
src/ed_checker.sv
sim/tb_euclidean_distance_unit.sv
